@@ rtl/gsp_pkg.sv @@
// Shared types, codes and helpers of the generational slot pool.
package gsp_pkg;

	// Default sizes of the pool
	localparam int SLOTS_DEF    = 64;
	localparam int GEN_BITS_DEF = 16;

	// Field widths of the request and result beats
	localparam int KIND_W = 2;
	localparam int SLOT_W = 6;
	localparam int GEN_W  = 16;
	localparam int MIDX_W = 12;
	localparam int MGEN_W = 16;
	localparam int STAT_W = 2;
	localparam int OP_W   = 3;

	// Request kinds as they arrive
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// Classified operations handed to the back end
	localparam logic [OP_W-1:0] OP_ALLOC       = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd1;
	localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
	localparam logic [OP_W-1:0] OP_NOP         = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP_OOR  = 3'd4;
	localparam logic [OP_W-1:0] OP_RELEASE_OOR = 3'd5;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_STALE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  generation;
		logic [MIDX_W-1:0] mesh_index;
		logic [MGEN_W-1:0] mesh_generation;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  generation;
		logic [MIDX_W-1:0] mesh_index;
		logic [MGEN_W-1:0] mesh_generation;
	} res_t;

	// Position of the lowest clear bit of a byte (0 when all set)
	function automatic logic [2:0] lowest_zero8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/gsp_fifo.sv @@
// Two-entry queue used between the front end, the back end and the result port.
module gsp_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/gsp_front.sv @@
// Front end: accepts request beats and classifies them into back-end operations.
module gsp_front #(
	parameter int SLOTS = gsp_pkg::SLOTS_DEF
) (
	input  logic                        push,
	input  logic                        busy,
	input  logic [gsp_pkg::KIND_W-1:0]  kind,
	input  logic [gsp_pkg::SLOT_W-1:0]  slot,
	input  logic [gsp_pkg::GEN_W-1:0]   generation,
	input  logic [gsp_pkg::MIDX_W-1:0]  mesh_index,
	input  logic [gsp_pkg::MGEN_W-1:0]  mesh_generation,
	output logic                        acc,
	output gsp_pkg::cmd_t               cmd
);

	logic in_range;

	assign acc      = push && !busy;
	assign in_range = ({26'd0, slot} < 32'(SLOTS));

	// Classify the request by kind and slot range
	always_comb begin
		cmd.slot            = slot;
		cmd.generation      = generation;
		cmd.mesh_index      = mesh_index;
		cmd.mesh_generation = mesh_generation;
		case (kind)
			gsp_pkg::KIND_ALLOC: begin
				cmd.op = gsp_pkg::OP_ALLOC;
			end
			gsp_pkg::KIND_LOOKUP: begin
				cmd.op = in_range ? gsp_pkg::OP_LOOKUP : gsp_pkg::OP_LOOKUP_OOR;
			end
			gsp_pkg::KIND_RELEASE: begin
				cmd.op = in_range ? gsp_pkg::OP_RELEASE : gsp_pkg::OP_RELEASE_OOR;
			end
			default: begin
				cmd.op = gsp_pkg::OP_NOP;
			end
		endcase
	end

endmodule

@@ rtl/gsp_scan.sv @@
// Two-stage registered search for the lowest free slot.
module gsp_scan #(
	parameter int SLOTS = gsp_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [SLOTS-1:0]         used,
	output logic                     found,
	output logic [$clog2(SLOTS)-1:0] idx
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int NGRP = (SLOTS + 7) / 8;

	logic [NGRP*8-1:0] pad;
	logic [NGRP-1:0]   grp_free_s1;
	logic [2:0]        grp_loc_s1 [NGRP];
	logic              found_c;
	logic [31:0]       pos_c;
	logic              found_s2;
	logic [IDXW-1:0]   idx_s2;

	// Pad the tail group with used slots
	always_comb begin
		pad = '1;
		pad[SLOTS-1:0] = used;
	end

	// Stage 1: per-byte free flag and lowest free position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_free_s1 <= '0;
		end else begin
			for (int g = 0; g < NGRP; g++) begin
				grp_free_s1[g] <= ~&pad[g*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_loc_s1[g] <= gsp_pkg::lowest_zero8(pad[g*8 +: 8]);
		end
	end

	// Stage 2: pick the first group with a free slot
	always_comb begin
		found_c = 1'b0;
		pos_c   = 32'd0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				found_c = 1'b1;
				pos_c   = (32'(g) << 3) | {29'd0, grp_loc_s1[g]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s2 <= 1'b0;
		end else begin
			found_s2 <= found_c;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= pos_c[IDXW-1:0];
	end

	assign found = found_s2;
	assign idx   = idx_s2;

endmodule

@@ rtl/gsp_back.sv @@
// Back end: slot memories, read-modify-write sequencer and result forming.
module gsp_back #(
	parameter int SLOTS    = gsp_pkg::SLOTS_DEF,
	parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gsp_pkg::cmd_t cmd_in,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output gsp_pkg::res_t res,
	output logic          clearing
);

	localparam int IDXW = $clog2(SLOTS);
	localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [GEN_BITS-1:0] gen_mem  [SLOTS];
	logic [27:0]         mesh_mem [SLOTS];

	logic [1:0]          st_q;
	logic [IDXW-1:0]     clr_q;
	logic [1:0]          settle_q;
	logic [SLOTS-1:0]    used_q;
	gsp_pkg::cmd_t       cmd_q;
	logic [IDXW-1:0]     addr_q;
	logic                found_q;
	logic [GEN_BITS-1:0] gen_rd_q;
	logic [27:0]         mesh_rd_q;

	logic                free_found;
	logic [IDXW-1:0]     free_idx;
	logic [12:0]         slot_ext;
	logic [IDXW-1:0]     slot_addr;
	logic [IDXW-1:0]     rd_addr;
	logic                issue;
	logic                exec;
	logic                do_alloc;
	logic                do_release;
	logic [GEN_BITS-1:0] gen_new;
	logic [32:0]         g33;
	logic [32:0]         gn33;
	logic [12:0]         a13;
	logic                gen_we;
	logic [IDXW-1:0]     gen_wa;
	logic [GEN_BITS-1:0] gen_wd;

	gsp_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.used  (used_q),
		.found (free_found),
		.idx   (free_idx)
	);

	// Decode issue conditions
	assign slot_ext  = {7'd0, cmd_in.slot};
	assign slot_addr = slot_ext[IDXW-1:0];
	assign rd_addr   = (cmd_in.op == gsp_pkg::OP_ALLOC) ? free_idx : slot_addr;
	assign issue     = (st_q == S_IDLE) && !cmd_empty && !res_full &&
	                   ((cmd_in.op != gsp_pkg::OP_ALLOC) || (settle_q == 2'd0));
	assign exec       = (st_q == S_EXEC);
	assign do_alloc   = exec && (cmd_q.op == gsp_pkg::OP_ALLOC) && found_q;
	assign do_release = exec && (cmd_q.op == gsp_pkg::OP_RELEASE);
	assign cmd_pop    = issue;
	assign res_push   = exec;
	assign clearing   = (st_q == S_CLEAR);

	// Latch the operation and read the slot
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_q     <= cmd_in;
			addr_q    <= rd_addr;
			found_q   <= free_found;
			gen_rd_q  <= gen_mem[rd_addr];
			mesh_rd_q <= mesh_mem[rd_addr];
		end
	end

	// Widen values for compare and output
	assign gen_new = gen_rd_q + 1'b1;
	assign g33     = {{(33-GEN_BITS){1'b0}}, gen_rd_q};
	assign gn33    = {{(33-GEN_BITS){1'b0}}, gen_new};
	assign a13     = {{(13-IDXW){1'b0}}, addr_q};

	// Form the result beat
	always_comb begin
		res.status          = gsp_pkg::STAT_OK;
		res.slot            = cmd_q.slot;
		res.generation      = '0;
		res.mesh_index      = '0;
		res.mesh_generation = '0;
		case (cmd_q.op)
			gsp_pkg::OP_ALLOC: begin
				if (found_q) begin
					res.slot       = a13[5:0];
					res.generation = g33[15:0];
				end else begin
					res.status = gsp_pkg::STAT_FULL;
					res.slot   = '0;
				end
			end
			gsp_pkg::OP_LOOKUP: begin
				res.generation = g33[15:0];
				if (g33 == {17'd0, cmd_q.generation}) begin
					res.mesh_index      = mesh_rd_q[27:16];
					res.mesh_generation = mesh_rd_q[15:0];
				end else begin
					res.status = gsp_pkg::STAT_STALE;
				end
			end
			gsp_pkg::OP_LOOKUP_OOR: begin
				res.status = gsp_pkg::STAT_STALE;
			end
			gsp_pkg::OP_RELEASE: begin
				res.generation = gn33[15:0];
			end
			default: begin
				res.status = gsp_pkg::STAT_OK;
			end
		endcase
	end

	// Select the generation write: clearing pass or release bump
	always_comb begin
		gen_we = clearing || do_release;
		gen_wa = clearing ? clr_q : addr_q;
		gen_wd = clearing ? '0 : gen_new;
	end

	// Write the slot memories
	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_wa] <= gen_wd;
		end
		if (do_alloc) begin
			mesh_mem[addr_q] <= {cmd_q.mesh_index, cmd_q.mesh_generation};
		end
	end

	// Sequence: clear, then issue and execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			clr_q    <= '0;
			settle_q <= 2'd0;
			used_q   <= '0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (issue) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
			// Hold off the next allocate until the free search sees this update
			if (do_alloc || do_release) begin
				settle_q <= 2'd2;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
			if (do_alloc) begin
				used_q[addr_q] <= 1'b1;
			end else if (do_release) begin
				used_q[addr_q] <= 1'b0;
			end
		end
	end

	// An allocate must land on a slot that is still free
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_alloc |-> !used_q[addr_q])
		else $error("allocate chose a used slot");

	// Room for the result is reserved at issue
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !res_full)
		else $error("result queue full during execute");

	// The clearing pass runs only after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_CLEAR) |=> (st_q != S_CLEAR))
		else $error("clearing pass re-entered");

	// Execute always follows an issue
	a_exec_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> exec)
		else $error("issued operation not executed");

endmodule

@@ rtl/generational_instance_slot_pool_top.sv @@
// A request beat reaches the result port via the command queue, the issue
// registers and the result queue. The back end issues one slot memory
// read-modify-write at a time; an allocate right after an allocate or release
// waits for the registered lowest-free search. Reset clears control state, then
// a clearing pass over all slots zeroes the generations while full stays high.
module generational_instance_slot_pool_top #(
	parameter int SLOTS    = gsp_pkg::SLOTS_DEF,
	parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [gsp_pkg::KIND_W-1:0]  kind,
	input  logic [gsp_pkg::SLOT_W-1:0]  slot,
	input  logic [gsp_pkg::GEN_W-1:0]   generation,
	input  logic [gsp_pkg::MIDX_W-1:0]  mesh_index,
	input  logic [gsp_pkg::MGEN_W-1:0]  mesh_generation,
	output logic                        empty,
	input  logic                        pop,
	output logic [gsp_pkg::STAT_W-1:0]  status,
	output logic [gsp_pkg::SLOT_W-1:0]  slot_out,
	output logic [gsp_pkg::GEN_W-1:0]   generation_out,
	output logic [gsp_pkg::MIDX_W-1:0]  mesh_index_out,
	output logic [gsp_pkg::MGEN_W-1:0]  mesh_generation_out
);

	localparam int CMD_W = $bits(gsp_pkg::cmd_t);
	localparam int RES_W = $bits(gsp_pkg::res_t);

	logic          busy;
	logic          acc;
	gsp_pkg::cmd_t cmd_w;
	logic          cq_full;
	logic          cq_empty;
	logic          cq_pop;
	logic [CMD_W-1:0] cq_rdata;
	gsp_pkg::cmd_t cmd_head;
	logic          clearing;
	logic          rq_full;
	logic          rq_push;
	gsp_pkg::res_t res_w;
	logic [RES_W-1:0] rq_rdata;
	gsp_pkg::res_t res_head;

	// Stall requests while the queue is full or memories are being cleared
	assign busy = cq_full || clearing;
	assign full = busy;

	gsp_front #(
		.SLOTS(SLOTS)
	) u_front (
		.push           (push),
		.busy           (busy),
		.kind           (kind),
		.slot           (slot),
		.generation     (generation),
		.mesh_index     (mesh_index),
		.mesh_generation(mesh_generation),
		.acc            (acc),
		.cmd            (cmd_w)
	);

	gsp_fifo #(
		.WIDTH(CMD_W)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (acc),
		.wdata (cmd_w),
		.rd    (cq_pop),
		.rdata (cq_rdata),
		.full  (cq_full),
		.empty (cq_empty)
	);

	assign cmd_head = cq_rdata;

	gsp_back #(
		.SLOTS   (SLOTS),
		.GEN_BITS(GEN_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_head),
		.cmd_empty(cq_empty),
		.cmd_pop  (cq_pop),
		.res_full (rq_full),
		.res_push (rq_push),
		.res      (res_w),
		.clearing (clearing)
	);

	gsp_fifo #(
		.WIDTH(RES_W)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (rq_push),
		.wdata (res_w),
		.rd    (pop),
		.rdata (rq_rdata),
		.full  (rq_full),
		.empty (empty)
	);

	// Drive the result ports from the oldest waiting beat
	assign res_head            = rq_rdata;
	assign status              = res_head.status;
	assign slot_out            = res_head.slot;
	assign generation_out      = res_head.generation;
	assign mesh_index_out      = res_head.mesh_index;
	assign mesh_generation_out = res_head.mesh_generation;

endmodule
